>>> hw/rtl/md5_digest_engine_macros.svh
// Assertion helpers shared by the RTL; all sample on clk_i and are off in reset.
`ifndef MD5_DIGEST_ENGINE_MACROS_SVH
`define MD5_DIGEST_ENGINE_MACROS_SVH

// Property holds on every cycle out of reset
`define MD5_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication
`define MD5_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define MD5_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/md5_pkg.sv
package md5_pkg;

  // Field widths
  localparam int unsigned WORD_W = 32;
  localparam int unsigned CNT_W  = 3;
  localparam int unsigned IDX_W  = 2;
  localparam int unsigned CFG_W  = 2;
  localparam int unsigned HASH_N = 4;

  // Block buffer and round counter
  localparam int unsigned BUF_DEPTH = 16;
  localparam int unsigned BUF_AW    = 4;
  localparam int unsigned RND_W     = 6;

  localparam logic [CNT_W-1:0]   BYTES_PER_WORD = CNT_W'(4);
  localparam logic [BUF_AW-1:0]  WPOS_LEN       = BUF_AW'(14);
  localparam logic [WORD_W-1:0]  PAD_WORD       = WORD_W'(32'h80);
  localparam logic [IDX_W-1:0]   DIG_LAST       = '1;

  // Standard MD5 initial chaining value
  localparam logic [WORD_W-1:0] CHAIN_RST [HASH_N] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
  };

  localparam logic [WORD_W-1:0] MD5_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // Rotate amounts, indexed by {phase, round[1:0]}
  localparam logic [4:0] MD5_S [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  // Message word index used by a round
  function automatic logic [BUF_AW-1:0] md5_gidx(input logic [RND_W-1:0] rnd);
    logic [BUF_AW-1:0] lo;
    logic [BUF_AW-1:0] g;
    lo = rnd[BUF_AW-1:0];
    unique case (rnd[RND_W-1:RND_W-2])
      2'd0:    g = lo;
      2'd1:    g = lo * BUF_AW'(5) + BUF_AW'(1);
      2'd2:    g = lo * BUF_AW'(3) + BUF_AW'(5);
      default: g = lo * BUF_AW'(7);
    endcase
    return g;
  endfunction

  function automatic logic [WORD_W-1:0] md5_rotl(input logic [WORD_W-1:0] v,
                                                  input logic [4:0] s);
    logic [2*WORD_W-1:0] dbl;
    dbl = {v, v} << s;
    return dbl[2*WORD_W-1:WORD_W];
  endfunction

  // Microcode step addresses
  localparam int unsigned STEP_W = 4;
  localparam logic [STEP_W-1:0] ADDR_IDLE   = STEP_W'(0);
  localparam logic [STEP_W-1:0] ADDR_PUSHW  = STEP_W'(1);
  localparam logic [STEP_W-1:0] ADDR_FPUSH  = STEP_W'(2);
  localparam logic [STEP_W-1:0] ADDR_F80    = STEP_W'(3);
  localparam logic [STEP_W-1:0] ADDR_FPAD   = STEP_W'(4);
  localparam logic [STEP_W-1:0] ADDR_FLEN   = STEP_W'(5);
  localparam logic [STEP_W-1:0] ADDR_FHI    = STEP_W'(6);
  localparam logic [STEP_W-1:0] ADDR_EMIT   = STEP_W'(7);
  localparam logic [STEP_W-1:0] ADDR_CLOAD  = STEP_W'(8);
  localparam logic [STEP_W-1:0] ADDR_CPRE   = STEP_W'(9);
  localparam logic [STEP_W-1:0] ADDR_CROUND = STEP_W'(10);
  localparam logic [STEP_W-1:0] ADDR_CFIN   = STEP_W'(11);

  // Datapath operation
  typedef enum logic [2:0] {
    DP_NONE, DP_CLOAD, DP_CPRE, DP_CROUND, DP_CFIN, DP_EMIT
  } dp_op_e;

  // Buffer write qualifier
  typedef enum logic [1:0] {
    PU_NONE, PU_ALWAYS, PU_CNT4, PU_NOT14
  } push_e;

  // Buffer write data source
  typedef enum logic [2:0] {
    SRC_WORD, SRC_LAST, SRC_PAD, SRC_ZERO, SRC_LEN
  } src_e;

  // Sequencing of the step counter
  typedef enum logic [2:0] {
    SQ_NEXT, SQ_GOTO, SQ_WAIT, SQ_UNTIL14, SQ_ROUND, SQ_EMIT, SQ_RET
  } seq_e;

  typedef struct packed {
    dp_op_e            op;
    push_e             push;
    src_e              src;
    seq_e              seq;
    logic [STEP_W-1:0] target;
    logic              take;
  } ucode_t;

  // Sequencer to datapath
  typedef struct packed {
    dp_op_e op;
    logic   push;
    src_e   src;
    logic   take;
  } ctrl_t;

  // Datapath to sequencer
  typedef struct packed {
    logic wpos_full;
    logic wpos_14;
    logic cnt4;
    logic rnd_last;
    logic emit_done;
  } stat_t;

  // Control store
  function automatic ucode_t md5_ucode(input logic [STEP_W-1:0] addr);
    ucode_t uc;
    unique case (addr)
      ADDR_IDLE:   uc = '{op: DP_NONE, push: PU_NONE, src: SRC_ZERO, seq: SQ_WAIT,
                          target: ADDR_FPUSH, take: 1'b1};
      ADDR_PUSHW:  uc = '{op: DP_NONE, push: PU_ALWAYS, src: SRC_WORD, seq: SQ_GOTO,
                          target: ADDR_IDLE, take: 1'b0};
      ADDR_FPUSH:  uc = '{op: DP_NONE, push: PU_ALWAYS, src: SRC_LAST, seq: SQ_NEXT,
                          target: ADDR_IDLE, take: 1'b0};
      ADDR_F80:    uc = '{op: DP_NONE, push: PU_CNT4, src: SRC_PAD, seq: SQ_NEXT,
                          target: ADDR_IDLE, take: 1'b0};
      ADDR_FPAD:   uc = '{op: DP_NONE, push: PU_NOT14, src: SRC_ZERO, seq: SQ_UNTIL14,
                          target: ADDR_IDLE, take: 1'b0};
      ADDR_FLEN:   uc = '{op: DP_NONE, push: PU_ALWAYS, src: SRC_LEN, seq: SQ_NEXT,
                          target: ADDR_IDLE, take: 1'b0};
      ADDR_FHI:    uc = '{op: DP_NONE, push: PU_ALWAYS, src: SRC_ZERO, seq: SQ_NEXT,
                          target: ADDR_IDLE, take: 1'b0};
      ADDR_EMIT:   uc = '{op: DP_EMIT, push: PU_NONE, src: SRC_ZERO, seq: SQ_EMIT,
                          target: ADDR_IDLE, take: 1'b0};
      ADDR_CLOAD:  uc = '{op: DP_CLOAD, push: PU_NONE, src: SRC_ZERO, seq: SQ_NEXT,
                          target: ADDR_IDLE, take: 1'b0};
      ADDR_CPRE:   uc = '{op: DP_CPRE, push: PU_NONE, src: SRC_ZERO, seq: SQ_NEXT,
                          target: ADDR_IDLE, take: 1'b0};
      ADDR_CROUND: uc = '{op: DP_CROUND, push: PU_NONE, src: SRC_ZERO, seq: SQ_ROUND,
                          target: ADDR_IDLE, take: 1'b0};
      ADDR_CFIN:   uc = '{op: DP_CFIN, push: PU_NONE, src: SRC_ZERO, seq: SQ_RET,
                          target: ADDR_IDLE, take: 1'b0};
      default:     uc = '{op: DP_NONE, push: PU_NONE, src: SRC_ZERO, seq: SQ_GOTO,
                          target: ADDR_IDLE, take: 1'b0};
    endcase
    return uc;
  endfunction

endpackage

>>> hw/rtl/md5_if.sv
// Message word channel
interface md5_in_if import md5_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] message_word;
  logic [CNT_W-1:0]  byte_count;
  logic              final_word;

  modport source (output valid, message_word, byte_count, final_word, input ready);
  modport sink   (input valid, message_word, byte_count, final_word, output ready);
endinterface

// Digest word channel
interface md5_out_if import md5_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] digest_word;
  logic [IDX_W-1:0]  digest_index;
  logic              digest_last;

  modport source (output valid, digest_word, digest_index, digest_last, input ready);
  modport sink   (input valid, digest_word, digest_index, digest_last, output ready);
endinterface

// Register write channel
interface md5_cfg_if import md5_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CFG_W-1:0]  index;
  logic [WORD_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/md5_ram.sv
module md5_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/md5_useq.sv
module md5_useq import md5_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_fire_i,
  input  logic  final_word_i,
  input  stat_t stat_i,
  output ctrl_t ctrl_o
);

  logic [STEP_W-1:0] step_q, step_d;
  logic [STEP_W-1:0] ret_q, ret_d;
  logic [STEP_W-1:0] step_inc;
  logic [STEP_W-1:0] nxt;
  ucode_t            uc;
  logic              push;

  assign uc       = md5_ucode(step_q);
  assign step_inc = step_q + STEP_W'(1);

  // Qualify the buffer write
  always_comb begin
    unique case (uc.push)
      PU_NONE:   push = 1'b0;
      PU_ALWAYS: push = 1'b1;
      PU_CNT4:   push = stat_i.cnt4;
      PU_NOT14:  push = !stat_i.wpos_14;
      default:   push = 1'b0;
    endcase
  end

  // Next step of the program
  always_comb begin
    unique case (uc.seq)
      SQ_NEXT:    nxt = step_inc;
      SQ_GOTO:    nxt = uc.target;
      SQ_WAIT: begin
        if (in_fire_i) begin
          nxt = final_word_i ? uc.target : step_inc;
        end else begin
          nxt = step_q;
        end
      end
      SQ_UNTIL14: nxt = stat_i.wpos_14 ? step_inc : step_q;
      SQ_ROUND:   nxt = stat_i.rnd_last ? step_inc : step_q;
      SQ_EMIT:    nxt = stat_i.emit_done ? uc.target : step_q;
      SQ_RET:     nxt = ret_q;
      default:    nxt = ADDR_IDLE;
    endcase
  end

  // A write that fills the block calls the compression routine
  always_comb begin
    ret_d  = ret_q;
    step_d = nxt;
    if (push && stat_i.wpos_full) begin
      ret_d  = nxt;
      step_d = ADDR_CLOAD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ADDR_IDLE;
      ret_q  <= ADDR_IDLE;
    end else begin
      step_q <= step_d;
      ret_q  <= ret_d;
    end
  end

  assign ctrl_o = '{op: uc.op, push: push, src: uc.src, take: uc.take};

endmodule

>>> hw/rtl/md5_dpath.sv
module md5_dpath import md5_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ctrl_t             ctrl_i,
  input  logic              in_fire_i,
  input  logic [WORD_W-1:0] message_word_i,
  input  logic [CNT_W-1:0]  byte_count_i,
  input  logic              final_word_i,
  input  logic              cfg_we_i,
  input  logic [CFG_W-1:0]  cfg_index_i,
  input  logic [WORD_W-1:0] cfg_data_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [WORD_W-1:0] digest_word_o,
  output logic [IDX_W-1:0]  digest_index_o,
  output logic              digest_last_o,
  output stat_t             stat_o
);

  logic [WORD_W-1:0] chain_q [HASH_N];
  logic [WORD_W-1:0] hash_q  [HASH_N];
  logic [WORD_W-1:0] a_q, b_q, c_q, d_q;
  logic [WORD_W-1:0] pre_q, pre_d;
  logic [RND_W-1:0]  rnd_q;
  logic [BUF_AW-1:0] wpos_q;
  logic [WORD_W-1:0] bt_q, bt_d;
  logic              in_msg_q;
  logic [WORD_W-1:0] word_q;
  logic [CNT_W-1:0]  cnt_q, cnt_norm;
  logic [IDX_W-1:0]  eidx_q;
  logic              out_valid_q;
  logic [WORD_W-1:0] out_word_q;
  logic [IDX_W-1:0]  out_idx_q;
  logic              out_last_q;

  logic [WORD_W-1:0] last_word;
  logic [WORD_W-1:0] push_data;
  logic [BUF_AW-1:0] raddr;
  logic [WORD_W-1:0] rdata;
  logic [WORD_W-1:0] f, sum, rot, b_new;
  logic [WORD_W-1:0] pre_base;
  logic [RND_W-1:0]  k_idx;
  logic              emit_fire;

  // Final byte count: out-of-range codes mean a full word
  assign cnt_norm = (byte_count_i == '0 || byte_count_i > BYTES_PER_WORD) ?
                    BYTES_PER_WORD : byte_count_i;

  // Final word with its 0x80 marker placed after the valid bytes
  always_comb begin
    unique case (cnt_q)
      CNT_W'(1): last_word = {16'h0, 8'h80, word_q[7:0]};
      CNT_W'(2): last_word = {8'h0, 8'h80, word_q[15:0]};
      CNT_W'(3): last_word = {8'h80, word_q[23:0]};
      default:   last_word = word_q;
    endcase
  end

  always_comb begin
    unique case (ctrl_i.src)
      SRC_WORD: push_data = word_q;
      SRC_LAST: push_data = last_word;
      SRC_PAD:  push_data = PAD_WORD;
      SRC_ZERO: push_data = '0;
      SRC_LEN:  push_data = {bt_q[WORD_W-4:0], 3'b000};
      default:  push_data = '0;
    endcase
  end

  // Read one round ahead so the message word is ready in time
  always_comb begin
    unique case (ctrl_i.op)
      DP_CLOAD: raddr = md5_gidx('0);
      DP_CPRE:  raddr = md5_gidx(RND_W'(1));
      default:  raddr = md5_gidx(rnd_q + RND_W'(2));
    endcase
  end

  md5_ram #(
    .WIDTH (WORD_W),
    .DEPTH (BUF_DEPTH)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.push),
    .waddr_i (wpos_q),
    .wdata_i (push_data),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Round function
  always_comb begin
    unique case (rnd_q[RND_W-1:RND_W-2])
      2'd0:    f = (b_q & c_q) | (~b_q & d_q);
      2'd1:    f = (b_q & d_q) | (c_q & ~d_q);
      2'd2:    f = b_q ^ c_q ^ d_q;
      default: f = c_q ^ (b_q | ~d_q);
    endcase
  end

  assign sum   = pre_q + f;
  assign rot   = md5_rotl(sum, MD5_S[{rnd_q[RND_W-1:RND_W-2], rnd_q[1:0]}]);
  assign b_new = b_q + rot;

  // a + K + M for the next round; the next a is the current d
  assign pre_base = (ctrl_i.op == DP_CPRE) ? a_q : d_q;
  assign k_idx    = (ctrl_i.op == DP_CPRE) ? '0 : rnd_q + RND_W'(1);
  assign pre_d    = pre_base + MD5_K[k_idx] + rdata;

  // Byte total: restarts with each message
  assign bt_d = (in_msg_q ? bt_q : '0) +
                WORD_W'(final_word_i ? cnt_norm : BYTES_PER_WORD);

  assign emit_fire = (ctrl_i.op == DP_EMIT) && (!out_valid_q || out_ready_i);

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q     <= CHAIN_RST;
      rnd_q       <= '0;
      wpos_q      <= '0;
      bt_q        <= '0;
      in_msg_q    <= 1'b0;
      eidx_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        chain_q[cfg_index_i] <= cfg_data_i;
      end
      if (ctrl_i.op == DP_CLOAD) begin
        rnd_q <= '0;
      end else if (ctrl_i.op == DP_CROUND) begin
        rnd_q <= rnd_q + RND_W'(1);
      end
      if (in_fire_i) begin
        bt_q     <= bt_d;
        in_msg_q <= 1'b1;
        if (!in_msg_q) begin
          wpos_q <= '0;
        end
      end else if (ctrl_i.push) begin
        wpos_q <= wpos_q + BUF_AW'(1);
      end
      if (emit_fire) begin
        eidx_q <= eidx_q + IDX_W'(1);
        if (eidx_q == DIG_LAST) begin
          in_msg_q <= 1'b0;
        end
      end
      if (emit_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      word_q <= message_word_i;
      cnt_q  <= cnt_norm;
      if (!in_msg_q) begin
        hash_q <= chain_q;
      end
    end
    if (ctrl_i.op == DP_CFIN) begin
      hash_q[0] <= hash_q[0] + a_q;
      hash_q[1] <= hash_q[1] + b_q;
      hash_q[2] <= hash_q[2] + c_q;
      hash_q[3] <= hash_q[3] + d_q;
    end
    if (ctrl_i.op == DP_CLOAD) begin
      a_q <= hash_q[0];
      b_q <= hash_q[1];
      c_q <= hash_q[2];
      d_q <= hash_q[3];
    end else if (ctrl_i.op == DP_CROUND) begin
      a_q <= d_q;
      b_q <= b_new;
      c_q <= b_q;
      d_q <= c_q;
    end
    if (ctrl_i.op == DP_CPRE || ctrl_i.op == DP_CROUND) begin
      pre_q <= pre_d;
    end
    if (emit_fire) begin
      out_word_q <= hash_q[eidx_q];
      out_idx_q  <= eidx_q;
      out_last_q <= (eidx_q == DIG_LAST);
    end
  end

  assign stat_o = '{
    wpos_full: (&wpos_q),
    wpos_14:   (wpos_q == WPOS_LEN),
    cnt4:      (cnt_q == BYTES_PER_WORD),
    rnd_last:  (&rnd_q),
    emit_done: emit_fire && (eidx_q == DIG_LAST)
  };

  assign out_valid_o    = out_valid_q;
  assign digest_word_o  = out_word_q;
  assign digest_index_o = out_idx_q;
  assign digest_last_o  = out_last_q;

endmodule

>>> hw/rtl/md5_digest_engine.sv
// Non-final word: accepted, then written to the buffer; a word that fills a block adds a compression
// (load, pre-add, 64 rounds, fold), during which no new word is accepted.
// Final word: padding writes plus one or two compressions, then four digest beats
// from one output register, one per cycle while the receiver is ready.
// Reset: step counter, counts and handshakes clear, chain registers take the MD5 IV;
// the block buffer is not cleared.
`include "md5_digest_engine_macros.svh"

module md5_digest_engine import md5_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  md5_in_if.sink    msg_i,
  md5_out_if.source dig_o,
  md5_cfg_if.sink   cfg_i
);

  ctrl_t ctrl;
  stat_t stat;
  logic  in_fire;

  assign msg_i.ready = ctrl.take;
  assign in_fire     = msg_i.valid && msg_i.ready;
  assign cfg_i.ready = 1'b1;

  // Program sequencer
  md5_useq u_useq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_fire_i    (in_fire),
    .final_word_i (msg_i.final_word),
    .stat_i       (stat),
    .ctrl_o       (ctrl)
  );

  // Buffer, round unit and digest output
  md5_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .in_fire_i      (in_fire),
    .message_word_i (msg_i.message_word),
    .byte_count_i   (msg_i.byte_count),
    .final_word_i   (msg_i.final_word),
    .cfg_we_i       (cfg_i.valid),
    .cfg_index_i    (cfg_i.index),
    .cfg_data_i     (cfg_i.data),
    .out_ready_i    (dig_o.ready),
    .out_valid_o    (dig_o.valid),
    .digest_word_o  (dig_o.digest_word),
    .digest_index_o (dig_o.digest_index),
    .digest_last_o  (dig_o.digest_last),
    .stat_o         (stat)
  );

  // A write into the last buffer slot must start a compression
  `MD5_ASSERT_NXT(a_wrap_call, ctrl.push && stat.wpos_full, ctrl.op == DP_CLOAD, "full block not compressed")
  // The 64th round is followed by the fold into the chaining value
  `MD5_ASSERT_NXT(a_round_end, ctrl.op == DP_CROUND && stat.rnd_last, ctrl.op == DP_CFIN, "round loop overran")
  // Last digest beat carries word D
  `MD5_ASSERT_IMP(a_last_idx, dig_o.valid && dig_o.digest_last, dig_o.digest_index == DIG_LAST, "last beat index wrong")
  // No message word is taken while the program is busy
  `MD5_ASSERT(a_busy_take, !(ctrl.take && (ctrl.push || ctrl.op != DP_NONE)), "input taken while busy")

endmodule

>>> tb/md5_digest_engine_checker.sv
`timescale 1ns / 1ps

module md5_digest_engine_checker import md5_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  md5_in_if    msg_i,
  md5_out_if   dig_i,
  md5_cfg_if   cfg_i,
  output int   err_count_o,
  output int   pending_o
);

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [IDX_W-1:0]  idx;
    logic              last;
  } digest_beat_t;

  localparam logic [31:0] PAD_BYTE = 32'h80;
  localparam int unsigned MAX_SHOWN = 10;

  // Chaining value after reset
  localparam logic [31:0] RESET_CHAIN [4] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
  };

  // Additive round constants
  localparam logic [31:0] ROUND_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // Left-rotate amounts per quarter, four per quarter
  localparam int unsigned ROT_AMT [16] = '{
    7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
  };

  logic [31:0]  start_chain [4];
  logic [31:0]  hash_st [4];
  logic [31:0]  blk_words [16];
  logic [31:0]  bytes_seen;
  logic [3:0]   wr_pos;
  logic         msg_open;
  digest_beat_t digest_q [$];
  int unsigned  shown;

  function automatic logic [31:0] rotate_left(input logic [31:0] v, input int unsigned s);
    return (v << s) | (v >> (32 - s));
  endfunction

  // 64 rounds over the buffered block, folded into the chaining value
  function automatic void run_rounds();
    logic [31:0] a, b, c, d, f, t;
    int unsigned g, ph;
    a = hash_st[0];
    b = hash_st[1];
    c = hash_st[2];
    d = hash_st[3];
    for (int unsigned r = 0; r < 64; r++) begin
      ph = r / 16;
      case (ph)
        0: begin
          f = (b & c) | (~b & d);
          g = r;
        end
        1: begin
          f = (b & d) | (c & ~d);
          g = (5 * r + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          g = (3 * r + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          g = (7 * r) % 16;
        end
      endcase
      t = a + f + ROUND_K[r] + blk_words[g];
      a = d;
      d = c;
      c = b;
      b = b + rotate_left(t, ROT_AMT[ph * 4 + r % 4]);
    end
    hash_st[0] = hash_st[0] + a;
    hash_st[1] = hash_st[1] + b;
    hash_st[2] = hash_st[2] + c;
    hash_st[3] = hash_st[3] + d;
  endfunction

  // Append one word to the block; a full block gets hashed
  function automatic void absorb(input logic [31:0] w);
    blk_words[wr_pos] = w;
    wr_pos = wr_pos + 4'd1;
    if (wr_pos == 4'd0) run_rounds();
  endfunction

  // Expected digest beats for one accepted message word
  function automatic void predict(input logic [31:0] w, input logic [2:0] cnt, input logic fin);
    logic [2:0]  n;
    logic [31:0] mask;
    if (!msg_open) begin
      hash_st    = start_chain;
      bytes_seen = '0;
      wr_pos     = '0;
      msg_open   = 1'b1;
    end
    if (!fin) begin
      bytes_seen = bytes_seen + 32'd4;
      absorb(w);
      return;
    end
    // Out-of-range count on the last word means a full word
    n = cnt;
    if (n == 3'd0 || n > 3'd4) n = 3'd4;
    bytes_seen = bytes_seen + 32'(n);
    if (n == 3'd4) begin
      absorb(w);
      absorb(PAD_BYTE);
    end else begin
      mask = (32'd1 << (8 * n)) - 32'd1;
      absorb((w & mask) | (PAD_BYTE << (8 * n)));
    end
    // No room left for the length: zero-fill into one more block
    if (wr_pos > 4'd14) begin
      while (wr_pos != 4'd0) absorb('0);
    end
    while (wr_pos < 4'd14) absorb('0);
    absorb(bytes_seen << 3);
    absorb('0);
    for (int unsigned k = 0; k < HASH_N; k++) begin
      digest_q.push_back('{word: hash_st[k], idx: IDX_W'(k), last: (k == HASH_N - 1)});
    end
    msg_open = 1'b0;
  endfunction

  // Watch all three channels
  always @(posedge clk_i or negedge rst_ni) begin : watch
    digest_beat_t want;
    digest_beat_t got;
    if (!rst_ni) begin
      start_chain = RESET_CHAIN;
      hash_st     = '{default: '0};
      bytes_seen  = '0;
      wr_pos      = '0;
      msg_open    = 1'b0;
      digest_q.delete();
      err_count_o = 0;
      shown       = 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) start_chain[cfg_i.index] = cfg_i.data;
      if (msg_i.valid && msg_i.ready) begin
        predict(msg_i.message_word, msg_i.byte_count, msg_i.final_word);
      end
      if (dig_i.valid && dig_i.ready) begin
        got = '{word: dig_i.digest_word, idx: dig_i.digest_index, last: dig_i.digest_last};
        if (digest_q.size() == 0) begin
          err_count_o++;
          if (shown < MAX_SHOWN) begin
            shown++;
            $display("%0t: unexpected digest beat word %h idx %0d last %0b",
                     $realtime, got.word, got.idx, got.last);
          end
        end else begin
          want = digest_q.pop_front();
          if (got != want) begin
            err_count_o++;
            if (shown < MAX_SHOWN) begin
              shown++;
              $display("%0t: digest mismatch: expected word %h idx %0d last %0b, got word %h idx %0d last %0b",
                       $realtime, want.word, want.idx, want.last, got.word, got.idx, got.last);
            end
          end
        end
      end
    end
    pending_o = digest_q.size();
  end

endmodule

>>> tb/md5_digest_engine_tb.sv
`timescale 1ns / 1ps

module md5_digest_engine_tb;
  import md5_pkg::*;

  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int unsigned PHASE_ITEMS  = 27;

  // Standard starting chain, word A in the low slice
  localparam logic [HASH_N-1:0][WORD_W-1:0] STD_CHAIN = {
    32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
  };

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  md5_in_if  msg_if ();
  md5_out_if dig_if ();
  md5_cfg_if cfg_if ();

  int          err_count;
  int          pending;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  bit          pressure_on   = 1'b0;
  bit          pressure_done = 1'b0;
  int unsigned hold_cnt      = 0;
  int unsigned cycle_cnt     = 0;

  always #6 clk_i = ~clk_i;

  md5_digest_engine dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .msg_i  (msg_if),
    .dig_o  (dig_if),
    .cfg_i  (cfg_if)
  );

  md5_digest_engine_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .msg_i       (msg_if),
    .dig_i       (dig_if),
    .cfg_i       (cfg_if),
    .err_count_o (err_count),
    .pending_o   (pending)
  );

  // Run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Digest receiver: random stalls, plus one long hold-off on request
  initial begin
    dig_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (pressure_on && !pressure_done) begin
        dig_if.ready <= 1'b0;
        hold_cnt++;
        if (hold_cnt == HOLD_CYCLES) pressure_done = 1'b1;
      end else begin
        dig_if.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // One message beat; returns at the falling edge after the handshake
  task automatic send_word(input logic [WORD_W-1:0] w, input logic [CNT_W-1:0] cnt,
                           input logic fin);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      msg_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    msg_if.valid        <= 1'b1;
    msg_if.message_word <= w;
    msg_if.byte_count   <= cnt;
    msg_if.final_word   <= fin;
    @(posedge clk_i);
    while (!msg_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Random content; last word mostly 1..4 bytes, sometimes an out-of-range count
  task automatic send_message(input int unsigned n_words);
    logic [CNT_W-1:0] last_cnt;
    if ($urandom_range(0, 7) == 0) begin
      last_cnt = CNT_W'($urandom_range(4, 7));
      if (last_cnt == BYTES_PER_WORD) last_cnt = '0;
    end else begin
      last_cnt = CNT_W'($urandom_range(1, 4));
    end
    for (int unsigned i = 1; i < n_words; i++) begin
      send_word($urandom, CNT_W'($urandom_range(0, 7)), 1'b0);
    end
    send_word($urandom, last_cnt, 1'b1);
  endtask

  task automatic write_chain(input logic [HASH_N-1:0][WORD_W-1:0] vals);
    for (int unsigned i = 0; i < HASH_N; i++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= CFG_W'(i);
      cfg_if.data  <= vals[i];
      @(posedge clk_i);
      while (!cfg_if.ready) @(posedge clk_i);
      @(negedge clk_i);
    end
    cfg_if.valid <= 1'b0;
  endtask

  // Drain all digests, then give the engine time to go idle
  task automatic settle();
    msg_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Mostly short messages, a few spanning two or more blocks; the last one is trimmed
  task automatic run_random_phase(input int unsigned n_items);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 18);
      if (len > n_items - sent) len = n_items - sent;
      send_message(len);
      sent += len;
    end
    settle();
  endtask

  initial begin
    logic [HASH_N-1:0][WORD_W-1:0] rnd_chain;
    msg_if.valid        = 1'b0;
    msg_if.message_word = '0;
    msg_if.byte_count   = '0;
    msg_if.final_word   = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.index        = '0;
    cfg_if.data         = '0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Single-word messages over every byte count, chain from reset
    for (int c = 0; c < 8; c++) begin
      send_word((c == 1) ? 32'h0000_0061 : (c[0] ? '1 : '0), CNT_W'(c), 1'b1);
    end
    // 14 full words: the pad byte takes slot 14, so the length spills to a second block
    for (int i = 0; i < 13; i++) begin
      send_word(i[0] ? '1 : '0, CNT_W'($urandom_range(0, 7)), 1'b0);
    end
    send_word($urandom, BYTES_PER_WORD, 1'b1);
    settle();

    // All-zero chain, no idling, one long receiver hold-off
    write_chain('0);
    pressure_on = 1'b1;
    run_random_phase(PHASE_ITEMS);

    // All-ones chain, sender mostly idle
    write_chain('1);
    send_idle_pct = 67;
    run_random_phase(PHASE_ITEMS);

    // Random chain, receiver mostly stalled
    for (int unsigned i = 0; i < HASH_N; i++) rnd_chain[i] = $urandom;
    write_chain(rnd_chain);
    send_idle_pct = 0;
    stall_pct     = 67;
    run_random_phase(PHASE_ITEMS);

    // Back to the standard chain, both sides idling
    write_chain(STD_CHAIN);
    send_idle_pct = 35;
    stall_pct     = 35;
    run_random_phase(PHASE_ITEMS);

    if (err_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
